FILE: hw/rtl/stt_pkg.sv
`default_nettype none

package stt_pkg;

  // Newline counter width and the width of the line number on the output
  localparam int unsigned LINE_BITS   = 32;
  localparam int unsigned LINE_NUM_W  = 32;

  // Decoupling queue between classifier and emitter
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic [LINE_BITS-1:0] line_cnt_t;

  typedef enum logic {
    KIND_TEXT = 1'b0,
    KIND_EOI  = 1'b1
  } in_kind_e;

  typedef enum logic {
    RES_CHAR = 1'b0,
    RES_END  = 1'b1
  } res_kind_e;

  typedef enum logic [1:0] {
    TOK_STRING  = 2'd0,
    TOK_WORD    = 2'd1,
    TOK_SPECIAL = 2'd2
  } tok_type_e;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_9 = 8'h39;

  // One classified byte: up to three results, always in this order:
  // word end marker, token character, closing end marker.
  typedef struct packed {
    logic                  word_end;
    logic                  char_v;
    logic                  tail_end;
    logic [7:0]            char_byte;
    tok_type_e             char_type;
    tok_type_e             end_type;
    logic                  unterm;
    logic [LINE_NUM_W-1:0] line;
  } op_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return ((c >= CH_LC_A) && (c <= CH_LC_Z)) ||
           ((c >= CH_UC_A) && (c <= CH_UC_Z)) ||
           ((c >= CH_DIG_0) && (c <= CH_DIG_9));
  endfunction

  // Low bits of the counter, zero extended when the counter is narrower
  function automatic logic [LINE_NUM_W-1:0] line_view(line_cnt_t c);
    logic [63:0] w;
    w = 64'(c);
    return w[LINE_NUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/stt_if.sv
`default_nettype none

interface stt_in_if import stt_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] text_byte;

  modport source (output valid, output kind, output text_byte, input ready);
  modport sink   (input valid, input kind, input text_byte, output ready);
endinterface

interface stt_out_if import stt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  result_kind;
  logic [7:0]            token_byte;
  logic [1:0]            token_type;
  logic [LINE_NUM_W-1:0] line_number;
  logic                  unterminated;
  logic                  last_of_run;

  modport source (output valid, output result_kind, output token_byte, output token_type,
                  output line_number, output unterminated, output last_of_run,
                  input ready);
  modport sink   (input valid, input result_kind, input token_byte, input token_type,
                  input line_number, input unterminated, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/source_text_tokenizer.sv
// Channel   Dir  Carries                                        Moves when
// in_i      in   kind, text_byte                                valid & ready
// out_o     out  result_kind, token_byte, token_type,           valid & ready
//                line_number, unterminated, last_of_run
//
// The classifier takes one byte per cycle while the 4-entry op queue has room.
// The emitter sends one result per cycle while out_o is ready, and a byte
// makes up to three results, or none; the emitter sets the sustained rate.
// Reset is asynchronous and clears all token state and the newline counter.
// A stalled output holds in its register; the queue absorbs bursts up front.
`default_nettype none

module source_text_tokenizer import stt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  stt_in_if.sink    in_i,
  stt_out_if.source out_o
);

  // classifier -> queue
  logic push;
  op_t  push_op;
  logic full;

  // queue -> emitter
  logic q_valid;
  op_t  q_op;
  logic pop;

  // Front: tracks string/word state and line count, turns each byte into
  // a compact op describing its results in emission order.
  stt_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .op_o   (push_op)
  );

  // Short queue so a stalled output does not block byte intake at once.
  stt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .op_o    (q_op)
  );

  // Back: walks the op's results one per transfer into the output register,
  // flags the final one and pops the op as that one loads.
  stt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .op_i    (q_op),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/stt_front.sv
`default_nettype none

module stt_front import stt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  stt_in_if.sink    in_i,
  input  wire logic full_i,
  output logic      push_o,
  output op_t       op_o
);

  logic      str_q, str_d;
  logic      word_q, word_d;
  logic      has_q, has_d;
  line_cnt_t cnt_q, cnt_d;
  logic      accept;
  logic      eoi;
  logic [7:0] c;
  op_t       op;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign eoi        = (in_i.kind == KIND_EOI);
  assign c          = in_i.text_byte;

  always_comb begin
    op           = '0;
    op.char_type = TOK_STRING;
    op.end_type  = TOK_STRING;
    str_d        = str_q;
    word_d       = word_q;
    has_d        = has_q;
    cnt_d        = cnt_q;
    if (eoi) begin
      // at most one of word / string is open
      op.word_end = word_q;
      op.tail_end = str_q;
      op.unterm   = str_q;
      op.line     = line_view(cnt_q);
      str_d       = 1'b0;
      word_d      = 1'b0;
      has_d       = 1'b0;
      cnt_d       = '0;
    end else begin
      if ((c == CH_LF) && (cnt_q != '1)) begin
        cnt_d = cnt_q + line_cnt_t'(1);
      end
      op.line = line_view(cnt_d);
      priority if (c == CH_QUOTE) begin
        if (str_q) begin
          op.tail_end = has_q;  // empty string gives nothing
          str_d       = 1'b0;
        end else begin
          op.word_end = word_q;
          word_d      = 1'b0;
          str_d       = 1'b1;
        end
        has_d = 1'b0;
      end else if (str_q) begin
        op.char_v    = 1'b1;
        op.char_byte = c;
        has_d        = 1'b1;
      end else if (is_space(c)) begin
        op.word_end = word_q;
        word_d      = 1'b0;
      end else if (is_alnum(c)) begin
        op.char_v    = 1'b1;
        op.char_byte = c;
        op.char_type = TOK_WORD;
        word_d       = 1'b1;
      end else begin
        op.word_end  = word_q;
        word_d       = 1'b0;
        op.char_v    = 1'b1;
        op.char_byte = c;
        op.char_type = TOK_SPECIAL;
        op.tail_end  = 1'b1;
        op.end_type  = TOK_SPECIAL;
      end
    end
  end

  assign push_o = accept && (op.word_end || op.char_v || op.tail_end);
  assign op_o   = op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      str_q  <= 1'b0;
      word_q <= 1'b0;
      has_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (accept) begin
      str_q  <= str_d;
      word_q <= word_d;
      has_q  <= has_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/stt_queue.sv
`default_nettype none

module stt_queue import stt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  op_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output op_t       op_o
);

  op_t                    mem_q [QUEUE_DEPTH];
  logic [QUEUE_IDX_W-1:0] wr_ptr_q;
  logic [QUEUE_IDX_W-1:0] rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] count_q;
  logic                   do_push;
  logic                   do_pop;

  function automatic logic [QUEUE_IDX_W-1:0] ptr_inc(logic [QUEUE_IDX_W-1:0] p);
    return (p == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_IDX_W'(1);
  endfunction

  assign full_o  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign op_o    = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QUEUE_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/stt_back.sv
`default_nettype none

module stt_back import stt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  input  wire op_t  op_i,
  output logic      pop_o,
  stt_out_if.source out_o
);

  // bit 2: word end, bit 1: character, bit 0: closing end marker
  logic [2:0] done_q;
  logic [2:0] pending;
  logic [2:0] sel;
  logic       load;
  logic       last;

  logic                  out_valid_q;
  res_kind_e             rk_d, rk_q;
  logic [7:0]            byte_d, byte_q;
  tok_type_e             type_d, type_q;
  logic                  unterm_d, unterm_q;
  logic [LINE_NUM_W-1:0] line_q;
  logic                  last_q;

  assign pending = {op_i.word_end, op_i.char_v, op_i.tail_end} & ~done_q;
  assign load    = valid_i && (!out_valid_q || out_o.ready);

  always_comb begin
    sel      = 3'b001;
    rk_d     = RES_END;
    byte_d   = 8'h00;
    type_d   = op_i.end_type;
    unterm_d = op_i.unterm;
    priority if (pending[2]) begin
      sel      = 3'b100;
      type_d   = TOK_WORD;
      unterm_d = 1'b0;
    end else if (pending[1]) begin
      sel      = 3'b010;
      rk_d     = RES_CHAR;
      byte_d   = op_i.char_byte;
      type_d   = op_i.char_type;
      unterm_d = 1'b0;
    end else begin
      sel = 3'b001;
    end
  end

  assign last  = ((pending & ~sel) == 3'b000);
  assign pop_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 3'b000;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        done_q      <= last ? 3'b000 : (done_q | sel);
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rk_q     <= rk_d;
      byte_q   <= byte_d;
      type_q   <= type_d;
      unterm_q <= unterm_d;
      line_q   <= op_i.line;
      last_q   <= last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_kind  = rk_q;
  assign out_o.token_byte   = byte_q;
  assign out_o.token_type   = type_q;
  assign out_o.line_number  = line_q;
  assign out_o.unterminated = unterm_q;
  assign out_o.last_of_run  = last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/stt_checker.sv
`default_nettype none

module stt_checker import stt_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  out_valid_i,
  input wire logic                  out_ready_i,
  input wire logic                  result_kind_i,
  input wire logic [7:0]            token_byte_i,
  input wire logic [1:0]            token_type_i,
  input wire logic [LINE_NUM_W-1:0] line_number_i,
  input wire logic                  unterminated_i,
  input wire logic                  last_of_run_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(token_byte_i) &&
      $stable(result_kind_i) && $stable(token_type_i) && $stable(line_number_i))
    else $error("stalled result changed");

  // end markers carry no byte
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == RES_END) |-> (token_byte_i == 8'h00))
    else $error("end marker with nonzero byte");

  // a special character is always followed by its own end marker
  a_special_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (result_kind_i == RES_CHAR) && (token_type_i == TOK_SPECIAL)
      |-> !last_of_run_i)
    else $error("special character flagged last");

  // unterminated only on a final string end marker
  a_unterm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && unterminated_i |-> (result_kind_i == RES_END) &&
      (token_type_i == TOK_STRING) && last_of_run_i)
    else $error("unterminated on wrong result");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .result_kind_i  (out_o.result_kind),
  .token_byte_i   (out_o.token_byte),
  .token_type_i   (out_o.token_type),
  .line_number_i  (out_o.line_number),
  .unterminated_i (out_o.unterminated),
  .last_of_run_i  (out_o.last_of_run)
);

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps

// Tokenizer testbench. Bytes go in on one channel; character and end-marker
// results come out on the other. A scoreboard tracks the token state and
// predicts every result. The checker compares each output transfer, field by
// field, with the oldest prediction. Several named tests run in turn: a
// directed pass over the corner cases, random source-like text, a long output
// stall, drain pauses, and a final stretch with no idling at all.
module tb_top;
  import stt_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer on either side
  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 20;

  // One predicted output transfer
  typedef struct packed {
    res_kind_e             rk;
    logic [7:0]            tbyte;
    tok_type_e             ttype;
    logic [LINE_NUM_W-1:0] line;
    logic                  unterm;
    logic                  last;
  } tok_res_t;

  logic clk;
  logic rst_n;

  stt_in_if  in_if ();
  stt_out_if out_if ();

  source_text_tokenizer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Scoreboard copy of the token state
  logic      sb_in_string;
  logic      sb_word_open;
  logic      sb_string_has_chars;
  line_cnt_t sb_newlines;
  tok_res_t  tok_expect_q[$];

  int  err_cnt      = 0;
  int  n_items      = 0;
  int  n_eoi        = 0;
  int  n_results    = 0;
  int  n_unterm     = 0;
  int  idle_cycles  = 0;
  bit  tx_idle_en   = 1'b1;
  bit  rx_idle_en   = 1'b1;
  int  rx_hold_req  = 0;
  int  rx_hold_left = 0;
  int  rx_gap_left  = 0;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Character classes, written independently of the design
  // ---------------------------------------------------------------------------
  function automatic bit is_sep(logic [7:0] c);
    return c inside {CH_SPACE, CH_LF, CH_TAB, CH_CR};
  endfunction

  function automatic bit is_wordch(logic [7:0] c);
    return c inside {[CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z], [CH_DIG_0:CH_DIG_9]};
  endfunction

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------
  function automatic void push_token_result(res_kind_e rk, logic [7:0] b, tok_type_e t,
                                            logic u);
    tok_res_t r;
    r.rk     = rk;
    r.tbyte  = b;
    r.ttype  = t;
    r.line   = LINE_NUM_W'(sb_newlines);  // line number already includes this byte's LF
    r.unterm = u;
    r.last   = 1'b0;
    tok_expect_q.push_back(r);
  endfunction

  function automatic void predict_tokens(in_kind_e k, logic [7:0] c);
    int       base;
    tok_res_t r;
    base = tok_expect_q.size();
    if (k == KIND_EOI) begin
      // close what is open, then back to the reset state, counter too
      if (sb_word_open) push_token_result(RES_END, 8'h00, TOK_WORD, 1'b0);
      if (sb_in_string) push_token_result(RES_END, 8'h00, TOK_STRING, 1'b1);
      sb_in_string        = 1'b0;
      sb_word_open        = 1'b0;
      sb_string_has_chars = 1'b0;
      sb_newlines         = '0;
    end else begin
      if (c == CH_LF && sb_newlines != '1) sb_newlines = sb_newlines + line_cnt_t'(1);
      if (c == CH_QUOTE) begin
        if (sb_in_string) begin
          // empty strings vanish
          if (sb_string_has_chars) push_token_result(RES_END, 8'h00, TOK_STRING, 1'b0);
          sb_in_string = 1'b0;
        end else begin
          if (sb_word_open) push_token_result(RES_END, 8'h00, TOK_WORD, 1'b0);
          sb_word_open = 1'b0;
          sb_in_string = 1'b1;
        end
        sb_string_has_chars = 1'b0;
      end else if (sb_in_string) begin
        push_token_result(RES_CHAR, c, TOK_STRING, 1'b0);
        sb_string_has_chars = 1'b1;
      end else if (is_sep(c)) begin
        if (sb_word_open) push_token_result(RES_END, 8'h00, TOK_WORD, 1'b0);
        sb_word_open = 1'b0;
      end else if (is_wordch(c)) begin
        push_token_result(RES_CHAR, c, TOK_WORD, 1'b0);
        sb_word_open = 1'b1;
      end else begin
        // special: up to three results (word end, char, special end)
        if (sb_word_open) push_token_result(RES_END, 8'h00, TOK_WORD, 1'b0);
        sb_word_open = 1'b0;
        push_token_result(RES_CHAR, c, TOK_SPECIAL, 1'b0);
        push_token_result(RES_END, 8'h00, TOK_SPECIAL, 1'b0);
      end
    end
    if (tok_expect_q.size() > base) begin
      r = tok_expect_q[tok_expect_q.size()-1];
      r.last = 1'b1;
      tok_expect_q[tok_expect_q.size()-1] = r;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  function automatic void check_token_result();
    tok_res_t e;
    if (tok_expect_q.size() == 0) begin
      $error("unexpected result: kind %0d byte %0h type %0d",
             out_if.result_kind, out_if.token_byte, out_if.token_type);
      err_cnt++;
    end else begin
      e = tok_expect_q.pop_front();
      check_field("result_kind",  32'(e.rk),     32'(out_if.result_kind));
      check_field("token_byte",   32'(e.tbyte),  32'(out_if.token_byte));
      check_field("token_type",   32'(e.ttype),  32'(out_if.token_type));
      check_field("line_number",  32'(e.line),   32'(out_if.line_number));
      check_field("unterminated", 32'(e.unterm), 32'(out_if.unterminated));
      check_field("last_of_run",  32'(e.last),   32'(out_if.last_of_run));
    end
  endfunction

  // Input monitor first, then output check, in one process: a prediction
  // always lands before any result that could depend on it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        predict_tokens(in_kind_e'(in_if.kind), in_if.text_byte);
        n_items++;
        if (in_if.kind == KIND_EOI) n_eoi++;
      end
      if (out_if.valid && out_if.ready) begin
        check_token_result();
        n_results++;
        if (out_if.unterminated) n_unterm++;
      end
    end
  end

  // Watchdog: counts cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Output-side ready: a long hold on request, else random bursts of stall when enabled
  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_if.ready <= 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (rx_idle_en && $urandom_range(0, 5) == 0) rx_gap_left = $urandom_range(1, 17);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // One input transfer. valid stays high between back-to-back items.
  task automatic send_item(in_kind_e k, logic [7:0] b);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= k;
    in_if.text_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted result has come out
  task automatic wait_drain();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (tok_expect_q.size() != 0);
  endtask

  function automatic logic [7:0] rand_alnum();
    case ($urandom_range(0, 2))
      0:       return CH_LC_A + 8'($urandom_range(0, 25));
      1:       return CH_UC_A + 8'($urandom_range(0, 25));
      default: return CH_DIG_0 + 8'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic logic [7:0] rand_sep();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_LF;
      2:       return CH_TAB;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] rand_special();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_wordch(c) || is_sep(c) || c == CH_QUOTE);
    return c;
  endfunction

  // Any byte but a quote, biased toward blanks and letters
  function automatic logic [7:0] rand_string_byte();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0:       return rand_sep();
      1:       return rand_alnum();
      default: begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
        return c;
      end
    endcase
  endfunction

  // A piece of source-like text; a minority is noise or broken input
  task automatic send_snippet();
    int sel;
    int len;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      len = $urandom_range(1, 8);
      repeat (len) send_item(KIND_TEXT, rand_alnum());
      if ($urandom_range(0, 1) == 0) send_item(KIND_TEXT, rand_sep());
    end else if (sel < 52) begin
      send_item(KIND_TEXT, CH_QUOTE);
      len = $urandom_range(0, 6);
      repeat (len) send_item(KIND_TEXT, rand_string_byte());
      if ($urandom_range(0, 9) != 0) send_item(KIND_TEXT, CH_QUOTE);  // else left open
    end else if (sel < 70) begin
      send_item(KIND_TEXT, rand_special());
    end else if (sel < 80) begin
      send_item(KIND_TEXT, rand_sep());
    end else if (sel < 93) begin
      send_item(KIND_TEXT, 8'($urandom_range(0, 255)));
    end else begin
      send_item(KIND_EOI, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random_text(int n);
    int target;
    target = n_items + n;
    while (n_items < target) send_snippet();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // alnum range edges build one word
    send_item(KIND_TEXT, CH_LC_A);
    send_item(KIND_TEXT, CH_LC_Z);
    send_item(KIND_TEXT, CH_UC_A);
    send_item(KIND_TEXT, CH_UC_Z);
    send_item(KIND_TEXT, CH_DIG_0);
    send_item(KIND_TEXT, CH_DIG_9);
    send_item(KIND_TEXT, CH_QUOTE);   // quote after word closes the word
    send_item(KIND_TEXT, CH_QUOTE);   // empty string: nothing
    send_item(KIND_TEXT, CH_LF);      // newline outside a string
    send_item(KIND_TEXT, 8'h00);      // special on its own
    send_item(KIND_TEXT, 8'h71);
    send_item(KIND_TEXT, 8'hFF);      // special after word, three results
    send_item(KIND_TEXT, CH_QUOTE);
    send_item(KIND_TEXT, CH_LF);      // newline inside a string still counts
    send_item(KIND_TEXT, CH_SPACE);
    send_item(KIND_TEXT, CH_QUOTE);
    send_item(KIND_TEXT, CH_TAB);
    send_item(KIND_TEXT, CH_CR);
    send_item(KIND_TEXT, 8'h78);
    send_item(KIND_EOI,  8'hFF);      // end of input with a word open
    send_item(KIND_TEXT, CH_QUOTE);
    send_item(KIND_EOI,  8'h00);      // unterminated, still empty
    send_item(KIND_TEXT, CH_QUOTE);
    send_item(KIND_TEXT, 8'h6B);
    send_item(KIND_EOI,  8'h55);      // unterminated with content
    send_item(KIND_EOI,  8'hAA);      // nothing open: no result
    wait_drain();
  endtask

  // Receiver holds off while the sender keeps offering bytes, so the op
  // queue fills and the input stalls.
  task automatic test_output_stall();
    tx_idle_en  = 1'b0;
    rx_hold_req = RX_HOLD_CYCLES;
    repeat (20) begin
      send_item(KIND_TEXT, rand_alnum());
      send_item(KIND_TEXT, rand_special());
    end
    wait_drain();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      repeat (6) send_snippet();
      wait_drain();
    end
  endtask

  task automatic test_no_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_random_text(50);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.kind          = KIND_TEXT;
    in_if.text_byte     = 8'h00;
    out_if.ready        = 1'b0;
    sb_in_string        = 1'b0;
    sb_word_open        = 1'b0;
    sb_string_has_chars = 1'b0;
    sb_newlines         = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    run_random_text(140);
    test_output_stall();
    test_drain_pause();
    run_random_text(60);
    test_no_idle();

    wait_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d input transfers (%0d end of input), %0d results checked,",
             n_items, n_eoi, n_results);
    $display("%0d unterminated strings, long output stall and drain pauses included",
             n_unterm);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: source_text_tokenizer.f
hw/rtl/stt_pkg.sv
hw/rtl/stt_if.sv
hw/rtl/stt_front.sv
hw/rtl/stt_queue.sv
hw/rtl/stt_back.sv
hw/rtl/source_text_tokenizer.sv
hw/rtl/stt_checker.sv
test/tb_top.sv
